[hdl/assert_macros.svh]
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge outside reset
`define LGE_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication checked at every rising edge outside reset
`define LGE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/lge_pkg.sv]
`default_nettype none
package lge_pkg;

	// grid geometry
	localparam int GRID_SIZE = 32;
	localparam int IDX_W = $clog2(GRID_SIZE);
	localparam int EXT_W = $clog2(GRID_SIZE + 1);

	// field widths fixed by the interface
	localparam int OPCODE_W = 2;
	localparam int INDEX_IN_W = 5;
	localparam int CFG_W = 6;
	localparam int CFG_IDX_W = 1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_EXTENT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SECOND_EXTENT = 1'b1;

	// operations
	localparam logic [OPCODE_W-1:0] OP_TOGGLE = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_READ = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_STEP = 2'd2;
	localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd3;

	// b3/s23 neighbour counts
	localparam logic [3:0] COUNT_KEEP = 4'd2;
	localparam logic [3:0] COUNT_BIRTH = 4'd3;

	// command queue
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	// decoded command
	typedef struct packed {
		logic [OPCODE_W-1:0] op;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic in_grid;
	} cmd_t;

	// saturated active region
	typedef struct packed {
		logic [EXT_W-1:0] rows;
		logic [EXT_W-1:0] cols;
	} extent_t;

	// saturate an extent register to the grid size
	function automatic logic [EXT_W-1:0] clamp_extent(input logic [CFG_W-1:0] e);
		logic [EXT_W-1:0] res;
		if (int'(e) > GRID_SIZE)
			res = EXT_W'(GRID_SIZE);
		else
			res = EXT_W'(e);
		return res;
	endfunction

endpackage
`default_nettype wire

[hdl/life_grid_engine.sv]
// Game of life engine on a 32 x 32 grid of one-bit cells (rule b3/s23), reset to all dead.
// Each input transaction gives exactly one result. A toggle or a read makes one registered read
// of the row memory, then the write-back for a toggle, then the result load. A step or a clear
// works on rows 0 to rows - 1, rows being first_extent saturated to 32: the back end sweeps the
// row memory one row a cycle with a three-row window, writing row r while it reads row r + 2.
// A step or clear with a zero row extent goes straight to the result load. A two-entry command
// queue lets new transactions be taken while an operation runs, and the result register lets
// work go on while a result waits. The extents apply to step and clear only and should be
// written while the block is idle.
`default_nettype none
module life_grid_engine (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [lge_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [lge_pkg::CFG_W-1:0] cfg_data,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [lge_pkg::OPCODE_W-1:0] opcode,
	input wire logic [lge_pkg::INDEX_IN_W-1:0] row_index,
	input wire logic [lge_pkg::INDEX_IN_W-1:0] col_index,
	output logic out_valid,
	input wire logic out_ready,
	output logic cell_value
);

	logic [lge_pkg::CFG_W-1:0] first_extent_q;
	logic [lge_pkg::CFG_W-1:0] second_extent_q;
	lge_pkg::extent_t ext;
	logic push_valid;
	logic push_ready;
	lge_pkg::cmd_t push_cmd;
	logic pop_valid;
	logic pop;
	lge_pkg::cmd_t pop_cmd;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_extent_q <= '0;
			second_extent_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				lge_pkg::REG_FIRST_EXTENT: first_extent_q <= cfg_data;
				lge_pkg::REG_SECOND_EXTENT: second_extent_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// saturated active region
	assign ext = {lge_pkg::clamp_extent(first_extent_q), lge_pkg::clamp_extent(second_extent_q)};

	lge_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.row_index(row_index),
		.col_index(col_index),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_cmd(push_cmd)
	);

	lge_cmd_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_cmd(push_cmd),
		.pop_valid(pop_valid),
		.pop(pop),
		.pop_cmd(pop_cmd)
	);

	lge_exec u_exec (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(pop_valid),
		.cmd_pop(pop),
		.cmd(pop_cmd),
		.ext(ext),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cell_value(cell_value)
	);

endmodule
`default_nettype wire

[hdl/lge_front.sv]
`default_nettype none
module lge_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [lge_pkg::OPCODE_W-1:0] opcode,
	input wire logic [lge_pkg::INDEX_IN_W-1:0] row_index,
	input wire logic [lge_pkg::INDEX_IN_W-1:0] col_index,
	output logic push_valid,
	input wire logic push_ready,
	output lge_pkg::cmd_t push_cmd
);

	logic valid_s1;
	lge_pkg::cmd_t cmd_s1;
	lge_pkg::cmd_t dec_cmd;

	// classify the incoming transaction
	always_comb begin
		dec_cmd.op = opcode;
		dec_cmd.row = lge_pkg::IDX_W'(row_index);
		dec_cmd.col = lge_pkg::IDX_W'(col_index);
		dec_cmd.in_grid = (int'(row_index) < lge_pkg::GRID_SIZE) &&
			(int'(col_index) < lge_pkg::GRID_SIZE);
	end

	assign in_ready = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_cmd = cmd_s1;

	// decode stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// decode stage payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1 <= dec_cmd;
		end
	end

endmodule
`default_nettype wire

[hdl/lge_cmd_fifo.sv]
`default_nettype none
`include "assert_macros.svh"
module lge_cmd_fifo (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push_valid,
	output logic push_ready,
	input wire lge_pkg::cmd_t push_cmd,
	output logic pop_valid,
	input wire logic pop,
	output lge_pkg::cmd_t pop_cmd
);

	lge_pkg::cmd_t slot_q [lge_pkg::FIFO_DEPTH];
	logic [lge_pkg::FIFO_PTR_W-1:0] wr_ptr_q;
	logic [lge_pkg::FIFO_PTR_W-1:0] rd_ptr_q;
	logic [lge_pkg::FIFO_CNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign push_ready = (int'(count_q) < lge_pkg::FIFO_DEPTH);
	assign pop_valid = (count_q != '0);
	assign pop_cmd = slot_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop && pop_valid;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				if (int'(wr_ptr_q) == lge_pkg::FIFO_DEPTH - 1)
					wr_ptr_q <= '0;
				else
					wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				if (int'(rd_ptr_q) == lge_pkg::FIFO_DEPTH - 1)
					rd_ptr_q <= '0;
				else
					rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	// fill level never passes the depth
	`LGE_ASSERT_IMPL(a_fifo_bound, 1'b1, int'(count_q) <= lge_pkg::FIFO_DEPTH, "fifo overfilled")
	// a lone push raises the fill level by one
	`LGE_ASSERT_NEXT(a_fifo_push, do_push && !do_pop, count_q == $past(count_q) + 1'b1, "push lost")

endmodule
`default_nettype wire

[hdl/lge_exec.sv]
`default_nettype none
`include "assert_macros.svh"
module lge_exec (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cmd_valid,
	output logic cmd_pop,
	input wire lge_pkg::cmd_t cmd,
	input wire lge_pkg::extent_t ext,
	output logic out_valid,
	input wire logic out_ready,
	output logic cell_value
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PRIME = 3'd1;
	localparam logic [2:0] ST_SWEEP = 3'd2;
	localparam logic [2:0] ST_TOG = 3'd3;
	localparam logic [2:0] ST_RD = 3'd4;
	localparam logic [2:0] ST_RESP = 3'd5;

	localparam int G = lge_pkg::GRID_SIZE;

	// grid rows with a live flag per row, cleared at reset
	logic [G-1:0] mem [G];
	logic [G-1:0] row_valid_q;
	logic [G-1:0] rd_data_q;

	logic [2:0] state_q;
	logic [lge_pkg::OPCODE_W-1:0] op_q;
	logic [lge_pkg::IDX_W-1:0] col_q;
	logic inside_q;
	logic [lge_pkg::IDX_W-1:0] r_q;
	logic [G-1:0] prev_q;
	logic [G-1:0] cur_q;
	logic res_q;
	logic out_valid_q;
	logic cell_value_q;

	// row address kept for the toggle write-back
	logic [lge_pkg::IDX_W-1:0] rd_addr_hold_q;

	logic rd_en;
	logic [lge_pkg::IDX_W-1:0] rd_addr;
	logic wr_en;
	logic [lge_pkg::IDX_W-1:0] wr_addr;
	logic [G-1:0] wr_data;
	logic [G-1:0] col_mask;
	logic [G-1:0] nxt_row;
	logic [G-1:0] new_row;
	logic sweep_last;
	logic slot_free;
	logic sel_bit;
	logic step_go;

	// b3/s23 update of one row from its two neighbours
	function automatic logic [G-1:0] life_row(input logic [G-1:0] up, input logic [G-1:0] mid,
		input logic [G-1:0] dn);
		logic [G+1:0] u;
		logic [G+1:0] m;
		logic [G+1:0] d;
		logic [3:0] n;
		logic [G-1:0] res;
		u = {1'b0, up, 1'b0};
		m = {1'b0, mid, 1'b0};
		d = {1'b0, dn, 1'b0};
		for (int c = 0; c < G; c++) begin
			n = 4'(u[c]) + 4'(u[c+1]) + 4'(u[c+2]) + 4'(m[c]) + 4'(m[c+2]) +
				4'(d[c]) + 4'(d[c+1]) + 4'(d[c+2]);
			res[c] = (n == lge_pkg::COUNT_BIRTH) || ((n == lge_pkg::COUNT_KEEP) && mid[c]);
		end
		return res;
	endfunction

	// columns inside the active region
	always_comb begin
		for (int c = 0; c < G; c++) begin
			col_mask[c] = (c < int'(ext.cols));
		end
	end

	// row below the window, dead beyond the grid edge
	assign nxt_row = (int'(r_q) + 1 < G) ? rd_data_q : '0;
	assign new_row = (op_q == lge_pkg::OP_STEP) ? life_row(prev_q, cur_q, nxt_row) : '0;
	assign sweep_last = (lge_pkg::EXT_W'(r_q) == ext.rows - 1'b1);
	assign slot_free = !out_valid_q || out_ready;
	assign sel_bit = rd_data_q[col_q];
	assign cmd_pop = (state_q == ST_IDLE) && cmd_valid;
	assign step_go = cmd_pop && (cmd.op == lge_pkg::OP_STEP) && (ext.rows != '0);

	// memory port control
	always_comb begin
		rd_en = 1'b0;
		rd_addr = '0;
		wr_en = 1'b0;
		wr_addr = r_q;
		wr_data = (new_row & col_mask) | (cur_q & ~col_mask);
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					rd_en = 1'b1;
					if (cmd.op == lge_pkg::OP_TOGGLE || cmd.op == lge_pkg::OP_READ)
						rd_addr = cmd.row;
				end
			end
			ST_PRIME: begin
				rd_en = 1'b1;
				rd_addr = lge_pkg::IDX_W'(1);
			end
			ST_SWEEP: begin
				wr_en = 1'b1;
				if (int'(r_q) + 2 < G) begin
					rd_en = 1'b1;
					rd_addr = r_q + lge_pkg::IDX_W'(2);
				end
			end
			ST_TOG: begin
				wr_en = inside_q;
				wr_addr = rd_addr_hold_q;
				wr_data = rd_data_q ^ (G'(1) << col_q);
			end
			default: begin
			end
		endcase
	end

	// grid memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= row_valid_q[rd_addr] ? mem[rd_addr] : '0;
		end
	end

	// row live flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
		end else if (wr_en) begin
			row_valid_q[wr_addr] <= 1'b1;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			r_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						case (cmd.op)
							lge_pkg::OP_TOGGLE: state_q <= ST_TOG;
							lge_pkg::OP_READ: state_q <= ST_RD;
							default: begin
								if (ext.rows == '0)
									state_q <= ST_RESP;
								else
									state_q <= ST_PRIME;
							end
						endcase
					end
				end
				ST_PRIME: begin
					r_q <= '0;
					state_q <= ST_SWEEP;
				end
				ST_SWEEP: begin
					r_q <= r_q + 1'b1;
					if (sweep_last)
						state_q <= ST_RESP;
				end
				ST_TOG: state_q <= ST_RESP;
				ST_RD: state_q <= ST_RESP;
				ST_RESP: begin
					if (slot_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				op_q <= cmd.op;
				col_q <= cmd.col;
				inside_q <= cmd.in_grid;
				rd_addr_hold_q <= cmd.row;
				res_q <= 1'b0;
				prev_q <= '0;
			end
			ST_PRIME: begin
				cur_q <= rd_data_q;
			end
			ST_SWEEP: begin
				prev_q <= cur_q;
				cur_q <= nxt_row;
			end
			ST_TOG: res_q <= inside_q && !sel_bit;
			ST_RD: res_q <= inside_q && sel_bit;
			default: begin
			end
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_RESP && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESP && slot_free) begin
			cell_value_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign cell_value = cell_value_q;

	// sweep never runs past the active rows
	`LGE_ASSERT_IMPL(a_sweep_rows, state_q == ST_SWEEP, lge_pkg::EXT_W'(r_q) < ext.rows, "sweep overrun")
	// commands are taken only between operations
	`LGE_ASSERT_IMPL(a_pop_idle, cmd_pop, state_q == ST_IDLE && !wr_en, "pop while busy")
	// a step over a non-empty region starts by priming the window
	`LGE_ASSERT_NEXT(a_step_prime, step_go, state_q == ST_PRIME, "step not primed")

endmodule
`default_nettype wire
